// File: rtl/bsb_pkg.sv
// ----------------------------------------------------------------------------
// bsb_pkg: shared definitions of the size bucket selector
// Sizes, widths, register indexes and the structs that pass between modules.
// ----------------------------------------------------------------------------
package bsb_pkg;

    localparam int MAX_BUDGET    = 64;
    localparam int MAX_ITEM_SIZE = 64;
    localparam int HANDLE_BITS   = 32;
    localparam int STACK_DEPTH   = 64;

    localparam int OUT_HANDLE_W = 32;
    localparam int SIZE_W       = 7;
    localparam int CNT_W        = 7;
    localparam int LIMIT_W      = 8;
    localparam int PCT_W        = 7;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 8;
    localparam int SIDX_W       = $clog2(MAX_ITEM_SIZE);
    localparam int DIDX_W       = $clog2(STACK_DEPTH);
    localparam int EADDR_W      = SIDX_W + DIDX_W;
    localparam int PROD_W       = 14;
    localparam int NUM_W        = 14;
    localparam int QBIT_W       = 3;

    localparam int PCT_SCALE = 100;
    localparam int PCT_LOW   = 75;
    localparam int PCT_HIGH  = 98;
    localparam int LIMIT_MIN = 2;
    localparam int LIMIT_MAX = 255;

    localparam logic [CFG_IDX_W-1:0] REG_LITERAL_BUDGET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_LIMIT     = 1'b1;

    localparam logic CMD_OFFER  = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    typedef struct packed {
        logic              rd_en;
        logic [SIDX_W-1:0] rd_addr;
        logic              wr_en;
        logic [SIDX_W-1:0] wr_addr;
        logic [CNT_W-1:0]  wr_data;
    } cnt_req_t;

    typedef struct packed {
        logic                   rd_en;
        logic [EADDR_W-1:0]     rd_addr;
        logic                   wr_en;
        logic [EADDR_W-1:0]     wr_addr;
        logic [HANDLE_BITS-1:0] wr_data;
    } ent_req_t;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quot;
    } div_res_t;

endpackage

// File: rtl/bsb_count_mem.sv
// ----------------------------------------------------------------------------
// bsb_count_mem: per-size stack counts
// Synchronous memory with registered read data; a valid bit per entry makes
// every count read as zero after reset until it is first written.
// ----------------------------------------------------------------------------
module bsb_count_mem (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  bsb_pkg::cnt_req_t         req,
    output logic [bsb_pkg::CNT_W-1:0] rd_data
);
    import bsb_pkg::*;

    logic [CNT_W-1:0]         mem [MAX_ITEM_SIZE];
    logic [MAX_ITEM_SIZE-1:0] valid_reg;
    logic [CNT_W-1:0]         rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= valid_reg[req.rd_addr] ? mem[req.rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/bsb_entry_ram.sv
// ----------------------------------------------------------------------------
// bsb_entry_ram: stacked item handles
// One row of STACK_DEPTH handles per size, registered read data.
// ----------------------------------------------------------------------------
module bsb_entry_ram (
    input  logic                            aclk,
    input  bsb_pkg::ent_req_t               req,
    output logic [bsb_pkg::HANDLE_BITS-1:0] rd_data
);
    import bsb_pkg::*;

    logic [HANDLE_BITS-1:0] mem [MAX_ITEM_SIZE*STACK_DEPTH];
    logic [HANDLE_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/bsb_divider.sv
// ----------------------------------------------------------------------------
// bsb_divider: fill percent divider
// Restoring division, one quotient bit per cycle, done pulses after the last.
// ----------------------------------------------------------------------------
module bsb_divider (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [bsb_pkg::NUM_W-1:0]  num,
    input  logic [bsb_pkg::SIZE_W-1:0] den,
    output bsb_pkg::div_res_t          res
);
    import bsb_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [PCT_W-1:0]  quot_reg;
    logic [QBIT_W-1:0] bit_reg;
    logic [SIZE_W-1:0] den_reg;
    logic [NUM_W-1:0]  shifted;

    assign shifted = NUM_W'(den_reg) << bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
            bit_reg  <= QBIT_W'(PCT_W - 1);
        end else if (busy_reg) begin
            if (rem_reg >= shifted) begin
                rem_reg           <= rem_reg - shifted;
                quot_reg[bit_reg] <= 1'b1;
            end
            bit_reg <= bit_reg - 1'b1;
        end
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;

endmodule

// File: rtl/budgeted_size_bucket_selector_core.sv
// ----------------------------------------------------------------------------
// budgeted_size_bucket_selector_core: budgeted per-size stack selector
// An offer reads the stack count, then writes the count and the handle.
// A select runs a counting walk over the stack counts, a percent divide
// for the fill percent, then an emit walk that pops the results; result
// stalls hold the emit walk. Reset clears the state machine, the result
// valid bit, the budget, the limit, the divider and the count valid bits.
// ----------------------------------------------------------------------------
module budgeted_size_bucket_selector_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [bsb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bsb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_cmd,
    input  logic [bsb_pkg::OUT_HANDLE_W-1:0] s_item_handle,
    input  logic [bsb_pkg::SIZE_W-1:0]       s_item_size,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_has_item,
    output logic [bsb_pkg::OUT_HANDLE_W-1:0] m_selected_handle,
    output logic [bsb_pkg::SIZE_W-1:0]       m_selected_size,
    output logic                             m_last_of_period,
    output logic [bsb_pkg::LIMIT_W-1:0]      m_export_limit,
    output logic [bsb_pkg::PCT_W-1:0]        m_fill_percent
);
    import bsb_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_OFF    = 4'd1;
    localparam logic [3:0] ST_P1_RD  = 4'd2;
    localparam logic [3:0] ST_P1_EV  = 4'd3;
    localparam logic [3:0] ST_P1_MOD = 4'd4;
    localparam logic [3:0] ST_MUL    = 4'd5;
    localparam logic [3:0] ST_DSTART = 4'd6;
    localparam logic [3:0] ST_DIV    = 4'd7;
    localparam logic [3:0] ST_EMPTY  = 4'd8;
    localparam logic [3:0] ST_P2_RD  = 4'd9;
    localparam logic [3:0] ST_P2_EV  = 4'd10;
    localparam logic [3:0] ST_P2_ER  = 4'd11;
    localparam logic [3:0] ST_P2_EL  = 4'd12;

    logic [3:0]             state_reg, state_next;
    logic [SIZE_W-1:0]      budget_reg;
    logic [LIMIT_W-1:0]     limit_reg, limit_next;
    logic [SIZE_W-1:0]      space_reg, space_next;
    logic [SIZE_W-1:0]      sz_reg, sz_next;
    logic [CNT_W-1:0]       ntot_reg, ntot_next;
    logic [CNT_W-1:0]       emit_reg, emit_next;
    logic [DIDX_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]       stk_reg, stk_next;
    logic                   whole_reg, whole_next;
    logic [HANDLE_BITS-1:0] hnd_reg, hnd_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [PCT_W-1:0]       pct_reg, pct_next;

    logic                    m_valid_reg, m_valid_next;
    logic                    o_has_reg;
    logic [HANDLE_BITS-1:0]  o_hnd_reg;
    logic [SIZE_W-1:0]       o_size_reg;
    logic                    o_last_reg;
    logic [LIMIT_W-1:0]      o_limit_reg;
    logic [PCT_W-1:0]        o_pct_reg;

    logic                   out_load, out_has, out_last;
    logic                   out_free;
    logic [SIZE_W-1:0]      bud_eff;
    logic [SIZE_W-1:0]      szm1, in_szm1;
    logic [CNT_W-1:0]       cnt_rd;
    logic [HANDLE_BITS-1:0] ent_rd;
    logic [PROD_W-1:0]      prod, off_prod;
    logic                   is_last;
    logic                   div_start;
    div_res_t               div_res;
    cnt_req_t               cnt_req;
    ent_req_t               ent_req;

    assign bud_eff = (budget_reg == '0) ? SIZE_W'(1) :
                     (budget_reg > SIZE_W'(MAX_BUDGET)) ? SIZE_W'(MAX_BUDGET) : budget_reg;
    assign szm1     = sz_reg - 1'b1;
    assign in_szm1  = s_item_size - 1'b1;
    assign prod     = PROD_W'(cnt_rd) * PROD_W'(sz_reg);
    assign off_prod = PROD_W'(sz_reg) * (PROD_W'(cnt_rd) + 1'b1);
    assign is_last  = (emit_reg + 1'b1) == ntot_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    bsb_count_mem u_cnt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cnt_req),
        .rd_data (cnt_rd)
    );

    bsb_entry_ram u_ent (
        .aclk    (aclk),
        .req     (ent_req),
        .rd_data (ent_rd)
    );

    bsb_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg),
        .den     (bud_eff),
        .res     (div_res)
    );

    always_comb begin
        state_next = state_reg;
        limit_next = limit_reg;
        space_next = space_reg;
        sz_next    = sz_reg;
        ntot_next  = ntot_reg;
        emit_next  = emit_reg;
        idx_next   = idx_reg;
        stk_next   = stk_reg;
        whole_next = whole_reg;
        hnd_next   = hnd_reg;
        num_next   = num_reg;
        pct_next   = pct_reg;
        out_load   = 1'b0;
        out_has    = 1'b0;
        out_last   = 1'b0;
        div_start  = 1'b0;
        cnt_req    = '0;
        ent_req    = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == CMD_SELECT) begin
                        space_next = bud_eff;
                        sz_next    = SIZE_W'(1);
                        ntot_next  = '0;
                        state_next = ST_P1_RD;
                    end else if (s_item_size != '0 &&
                                 s_item_size <= SIZE_W'(MAX_ITEM_SIZE)) begin
                        cnt_req.rd_en   = 1'b1;
                        cnt_req.rd_addr = in_szm1[SIDX_W-1:0];
                        sz_next         = s_item_size;
                        hnd_next        = s_item_handle[HANDLE_BITS-1:0];
                        state_next      = ST_OFF;
                    end
                end
            end
            ST_OFF: begin
                if (cnt_rd < CNT_W'(STACK_DEPTH) && off_prod <= PROD_W'(bud_eff)) begin
                    cnt_req.wr_en   = 1'b1;
                    cnt_req.wr_addr = szm1[SIDX_W-1:0];
                    cnt_req.wr_data = cnt_rd + 1'b1;
                    ent_req.wr_en   = 1'b1;
                    ent_req.wr_addr = {szm1[SIDX_W-1:0], cnt_rd[DIDX_W-1:0]};
                    ent_req.wr_data = hnd_reg;
                end
                state_next = ST_IDLE;
            end
            // Counting walk: finds the space left and the number of results.
            ST_P1_RD: begin
                if (sz_reg > SIZE_W'(MAX_ITEM_SIZE) || space_reg < sz_reg) begin
                    state_next = ST_MUL;
                end else begin
                    cnt_req.rd_en   = 1'b1;
                    cnt_req.rd_addr = szm1[SIDX_W-1:0];
                    state_next      = ST_P1_EV;
                end
            end
            ST_P1_EV: begin
                if (prod <= PROD_W'(space_reg)) begin
                    space_next = space_reg - prod[SIZE_W-1:0];
                    ntot_next  = ntot_reg + cnt_rd;
                    sz_next    = sz_reg + 1'b1;
                    state_next = ST_P1_RD;
                end else begin
                    state_next = ST_P1_MOD;
                end
            end
            ST_P1_MOD: begin
                if (space_reg >= sz_reg) begin
                    space_next = space_reg - sz_reg;
                    ntot_next  = ntot_reg + 1'b1;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                num_next   = NUM_W'(bud_eff - space_reg) * NUM_W'(PCT_SCALE);
                state_next = ST_DSTART;
            end
            ST_DSTART: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_res.done) begin
                    pct_next = div_res.quot;
                    if (div_res.quot < PCT_W'(PCT_LOW) && limit_reg != LIMIT_W'(LIMIT_MAX)) begin
                        limit_next = limit_reg + 1'b1;
                    end
                    if (div_res.quot > PCT_W'(PCT_HIGH) && limit_reg > LIMIT_W'(LIMIT_MIN)) begin
                        limit_next = limit_reg - 1'b1;
                    end
                    space_next = bud_eff;
                    sz_next    = SIZE_W'(1);
                    emit_next  = '0;
                    state_next = (ntot_reg == '0) ? ST_EMPTY : ST_P2_RD;
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            // Emit walk: repeats the counting walk and pops the handles.
            ST_P2_RD: begin
                if (sz_reg > SIZE_W'(MAX_ITEM_SIZE) || space_reg < sz_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_req.rd_en   = 1'b1;
                    cnt_req.rd_addr = szm1[SIDX_W-1:0];
                    state_next      = ST_P2_EV;
                end
            end
            ST_P2_EV: begin
                stk_next = cnt_rd;
                if (prod <= PROD_W'(space_reg)) begin
                    whole_next = 1'b1;
                    idx_next   = '0;
                    if (cnt_rd == '0) begin
                        sz_next    = sz_reg + 1'b1;
                        state_next = ST_P2_RD;
                    end else begin
                        state_next = ST_P2_ER;
                    end
                end else begin
                    whole_next = 1'b0;
                    idx_next   = DIDX_W'(cnt_rd - 1'b1);
                    state_next = ST_P2_ER;
                end
            end
            ST_P2_ER: begin
                if (out_free) begin
                    ent_req.rd_en   = 1'b1;
                    ent_req.rd_addr = {szm1[SIDX_W-1:0], idx_reg};
                    state_next      = ST_P2_EL;
                end
            end
            ST_P2_EL: begin
                out_load   = 1'b1;
                out_has    = 1'b1;
                out_last   = is_last;
                emit_next  = emit_reg + 1'b1;
                space_next = space_reg - sz_reg;
                if (whole_reg) begin
                    if (CNT_W'(idx_reg) + 1'b1 == stk_reg) begin
                        cnt_req.wr_en   = 1'b1;
                        cnt_req.wr_addr = szm1[SIDX_W-1:0];
                        cnt_req.wr_data = '0;
                        sz_next         = sz_reg + 1'b1;
                        state_next      = is_last ? ST_IDLE : ST_P2_RD;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_P2_ER;
                    end
                end else begin
                    stk_next = stk_reg - 1'b1;
                    if (is_last) begin
                        cnt_req.wr_en   = 1'b1;
                        cnt_req.wr_addr = szm1[SIDX_W-1:0];
                        cnt_req.wr_data = stk_reg - 1'b1;
                        state_next      = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = ST_P2_ER;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A write of the initial limit also reloads the running limit.
        if (cfg_we && cfg_index == REG_INIT_LIMIT) begin
            limit_next = (cfg_wdata < CFG_DATA_W'(LIMIT_MIN)) ?
                         LIMIT_W'(LIMIT_MIN) : LIMIT_W'(cfg_wdata);
        end
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            budget_reg  <= SIZE_W'(MAX_BUDGET);
            limit_reg   <= LIMIT_W'(LIMIT_MIN);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            limit_reg   <= limit_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_LITERAL_BUDGET: begin
                        budget_reg <= cfg_wdata[SIZE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        space_reg <= space_next;
        sz_reg    <= sz_next;
        ntot_reg  <= ntot_next;
        emit_reg  <= emit_next;
        idx_reg   <= idx_next;
        stk_reg   <= stk_next;
        whole_reg <= whole_next;
        hnd_reg   <= hnd_next;
        num_reg   <= num_next;
        pct_reg   <= pct_next;
        if (out_load) begin
            o_has_reg   <= out_has;
            o_hnd_reg   <= out_has ? ent_rd : '0;
            o_size_reg  <= out_has ? sz_reg : '0;
            o_last_reg  <= out_last;
            o_limit_reg <= limit_reg;
            o_pct_reg   <= pct_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_has_item        = o_has_reg;
    assign m_selected_handle = OUT_HANDLE_W'(o_hnd_reg);
    assign m_selected_size   = o_size_reg;
    assign m_last_of_period  = o_last_reg;
    assign m_export_limit    = o_limit_reg;
    assign m_fill_percent    = o_pct_reg;

endmodule

// File: rtl/bsb_checker.sv
// ----------------------------------------------------------------------------
// bsb_checker: port-level checks of the selector
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module bsb_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic                             m_has_item,
    input logic [bsb_pkg::OUT_HANDLE_W-1:0] m_selected_handle,
    input logic [bsb_pkg::SIZE_W-1:0]       m_selected_size,
    input logic                             m_last_of_period
);
    import bsb_pkg::*;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_selected_handle))
        else $error("stalled result beat changed");

    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_item |-> m_last_of_period && m_selected_size == '0 &&
        m_selected_handle == '0)
        else $error("empty result beat malformed");

    a_size_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_has_item |-> m_selected_size != '0 &&
        m_selected_size <= SIZE_W'(MAX_ITEM_SIZE))
        else $error("selected size out of range");

endmodule

bind budgeted_size_bucket_selector_core bsb_checker u_bsb_checker (.*);
